### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sorted timer set RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types, widths and codes shared by the sorted timer set modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

   // Field widths
   localparam int ACT_W = 2;
   localparam int ID_W  = 4;
   localparam int TMO_W = 31;
   localparam int NOW_W = 40;
   localparam int EXP_W = 41;
   localparam int REM_W = 32;

   // Number of distinct timer identifiers the id field can name
   localparam int NUM_IDS = 16;

   // Default number of timers
   localparam int TIMERS_DEF = 16;

   // Depth of the command queue between front and back
   localparam int CMD_QUEUE_DEPTH = 2;

   // Remaining-time answers
   localparam logic signed [REM_W-1:0] REM_NONE = -32'sd1;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef enum logic {
      KIND_FIRED  = 1'b0,
      KIND_ANSWER = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_PLACE,
      ST_FIRE
   } back_state_type;

   // Classified command: stamp is the expiry for insert, the current time otherwise
   typedef struct packed {
      action_type            act;
      logic [ID_W-1:0]       id;
      logic [EXP_W-1:0]      stamp;
   } cmd_type;

endpackage

`default_nettype wire

### design/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Accepts request transactions, drops inserts and cancels on identifiers
// outside the timer range, computes expiry stamps and pushes commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_front #(
   parameter int TIMERS = sts_pkg::TIMERS_DEF
) (
   input  wire logic                     start,
   input  wire logic [sts_pkg::ACT_W-1:0] req_action,
   input  wire logic [sts_pkg::ID_W-1:0]  req_timer_id,
   input  wire logic [sts_pkg::TMO_W-1:0] req_timeout_ms,
   input  wire logic [sts_pkg::NOW_W-1:0] req_now_ms,
   input  wire logic                     queue_full,
   output      logic                     push,
   output      sts_pkg::cmd_type         push_cmd
);
   import sts_pkg::*;

   localparam int SLOTS = (TIMERS < NUM_IDS) ? TIMERS : NUM_IDS;

   action_type act;
   logic       id_ok;
   logic       drop;

   // Decode and validate the request
   always_comb begin
      act   = action_type'(req_action);
      id_ok = (ID_W + 1)'(req_timer_id) < (ID_W + 1)'(SLOTS);
      drop  = ((act == ACT_INSERT) || (act == ACT_CANCEL)) && !id_ok;
   end

   // Build the command, with the expiry sum for inserts
   always_comb begin
      push_cmd.act = act;
      push_cmd.id  = req_timer_id;
      if (act == ACT_INSERT) begin
         push_cmd.stamp = EXP_W'(req_now_ms) + EXP_W'(req_timeout_ms);
      end else begin
         push_cmd.stamp = EXP_W'(req_now_ms);
      end
      push = start && !queue_full && !drop;
   end

endmodule

`default_nettype wire

### design/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue
// Short command queue that decouples the front from the list engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sts_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sts_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output      logic             full,
   output      logic             head_valid,
   output      sts_pkg::cmd_type head_cmd
);
   import sts_pkg::*;

   localparam int DEPTH = CMD_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   `ASSERT_NEVER(a_no_push_full, clock, reset, push && full && !pop, "push into full queue")
   `ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && !head_valid, "pop from empty queue")
   `ASSERT_PROP(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue overflow")

endmodule

`default_nettype wire

### design/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// List engine: keeps armed timers in slots sorted by expiry, walks the slots
// one per cycle for cancel and sorted insert, fires expired timers on tick
// and answers remaining-time queries through a registered result port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sts_back #(
   parameter int TIMERS = sts_pkg::TIMERS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      head_valid,
   input  wire sts_pkg::cmd_type          head_cmd,
   output      logic                      pop,
   output      logic                      rsp_valid,
   output      logic                      rsp_kind,
   output      logic [sts_pkg::ID_W-1:0]  rsp_fired_id,
   output      logic signed [sts_pkg::REM_W-1:0] rsp_remaining_ms,
   output      logic                      rsp_last
);
   import sts_pkg::*;

   localparam int SLOTS = (TIMERS < NUM_IDS) ? TIMERS : NUM_IDS;
   localparam int PW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);

   back_state_type           state_ff, state_in;
   cmd_type                  cur_ff, cur_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [SLOTS-1:0]         armed_ff, armed_in;
   logic [ID_W-1:0]          slot_id_ff  [SLOTS];
   logic [ID_W-1:0]          slot_id_in  [SLOTS];
   logic [EXP_W-1:0]         slot_exp_ff [SLOTS];
   logic [EXP_W-1:0]         slot_exp_in [SLOTS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic signed [REM_W-1:0]  rsp_rem_ff, rsp_rem_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     shl_en, shr_en;
   logic [PW-1:0]            shift_pos;
   logic                     head_armed, cur_armed;
   logic [EXP_W-1:0]         diff;
   logic signed [REM_W-1:0]  query_rem;
   logic                     fire0, fire1;

   assign head_armed = armed_ff[head_cmd.id[PW-1:0]];
   assign cur_armed  = armed_ff[cur_ff.id[PW-1:0]];

   // Remaining time to the head of the list, saturated
   always_comb begin
      diff = slot_exp_ff[0] - head_cmd.stamp;
      if (count_ff == '0) begin
         query_rem = REM_NONE;
      end else if (slot_exp_ff[0] <= head_cmd.stamp) begin
         query_rem = '0;
      end else if (diff[EXP_W-1:REM_W-1] != '0) begin
         query_rem = {1'b0, {(REM_W - 1){1'b1}}};
      end else begin
         query_rem = {1'b0, diff[REM_W-2:0]};
      end
   end

   // Expiry checks on the two head slots for tick
   assign fire0 = (count_ff != '0) && (slot_exp_ff[0] <= cur_ff.stamp);
   assign fire1 = (count_ff > CW'(1)) && (slot_exp_ff[1] <= cur_ff.stamp);

   // Sequencer: next state, list control and result
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      armed_in     = armed_ff;
      pop          = 1'b0;
      shl_en       = 1'b0;
      shr_en       = 1'b0;
      shift_pos    = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = KIND_FIRED;
      rsp_id_in    = '0;
      rsp_rem_in   = '0;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cur_in = head_cmd;
               pos_in = '0;
               case (head_cmd.act)
                  ACT_INSERT: begin
                     state_in = head_armed ? ST_FIND : ST_PLACE;
                  end
                  ACT_CANCEL: begin
                     state_in = head_armed ? ST_FIND : ST_IDLE;
                  end
                  ACT_TICK: begin
                     state_in = ST_FIRE;
                  end
                  ACT_QUERY: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_ANSWER;
                     rsp_rem_in   = query_rem;
                     rsp_last_in  = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FIND: begin
            // Walk until the slot holding this timer, then close the gap
            if (slot_id_ff[pos_ff] == cur_ff.id) begin
               shl_en                      = 1'b1;
               armed_in[cur_ff.id[PW-1:0]] = 1'b0;
               count_in                    = count_ff - CW'(1);
               pos_in                      = '0;
               state_in = (cur_ff.act == ACT_INSERT) ? ST_PLACE : ST_IDLE;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
         ST_PLACE: begin
            // Skip entries expiring at or before the new one, then open a slot
            if ((CW'(pos_ff) < count_ff) && (slot_exp_ff[pos_ff] <= cur_ff.stamp)) begin
               pos_in = pos_ff + PW'(1);
            end else begin
               shr_en                      = 1'b1;
               armed_in[cur_ff.id[PW-1:0]] = 1'b1;
               count_in                    = count_ff + CW'(1);
               state_in                    = ST_IDLE;
            end
         end
         ST_FIRE: begin
            // Pop one expired head per cycle
            if (fire0) begin
               shl_en                         = 1'b1;
               shift_pos                      = '0;
               armed_in[slot_id_ff[0][PW-1:0]] = 1'b0;
               count_in                       = count_ff - CW'(1);
               rsp_valid_in                   = 1'b1;
               rsp_kind_in                    = KIND_FIRED;
               rsp_id_in                      = slot_id_ff[0];
               rsp_last_in                    = !fire1;
               if (!fire1) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Slot list shifts
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_id_in[i]  = slot_id_ff[i];
         slot_exp_in[i] = slot_exp_ff[i];
      end
      if (shl_en) begin
         for (int i = 0; i < SLOTS - 1; i++) begin
            if (PW'(i) >= shift_pos) begin
               slot_id_in[i]  = slot_id_ff[i + 1];
               slot_exp_in[i] = slot_exp_ff[i + 1];
            end
         end
      end
      if (shr_en) begin
         for (int i = 1; i < SLOTS; i++) begin
            if (PW'(i) > shift_pos) begin
               slot_id_in[i]  = slot_id_ff[i - 1];
               slot_exp_in[i] = slot_exp_ff[i - 1];
            end
         end
         slot_id_in[shift_pos]  = cur_ff.id;
         slot_exp_in[shift_pos] = cur_ff.stamp;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         armed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_last_ff <= rsp_last_in;
      for (int i = 0; i < SLOTS; i++) begin
         slot_id_ff[i]  <= slot_id_in[i];
         slot_exp_ff[i] <= slot_exp_in[i];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fired_id     = rsp_id_ff;
   assign rsp_remaining_ms = rsp_rem_ff;
   assign rsp_last         = rsp_last_ff;

   `ASSERT_PROP(a_count_armed, clock, reset, $countones(armed_ff) == int'(count_ff), "count mismatch")
   `ASSERT_PROP(a_find_armed, clock, reset, (state_ff == ST_FIND) |-> cur_armed, "search for unarmed timer")
   `ASSERT_PROP(a_answer_last, clock, reset, (rsp_valid_ff && rsp_kind_ff) |-> rsp_last_ff, "answer not last")

endmodule

`default_nettype wire

### design/sorted_timer_set.sv
// ----------------------------------------------------------------------------
// sorted_timer_set
// One-shot timers kept in a list sorted by expiry, with insert, cancel,
// tick and remaining-time query commands.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Results appear on the rsp_ ports for
// one cycle each, flagged by rsp_valid, and cannot be held off: the receiver
// must take every strobe. Inserts and cancels on identifiers beyond the timer
// count are dropped at the input. Once a command leaves the queue, a query
// answers through the registered result port; a cancel of an armed timer
// walks the list to its slot and closes the gap; an insert first removes
// the timer if it was armed, then walks past entries expiring at or before
// it and opens a slot; a tick pops expired heads in order, with fired
// results on consecutive cycles. Cancel and insert walks are done by the
// list engine, which compares one list slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_set #(
   parameter int TIMERS = sts_pkg::TIMERS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic [sts_pkg::ACT_W-1:0]  req_action,
   input  wire logic [sts_pkg::ID_W-1:0]   req_timer_id,
   input  wire logic [sts_pkg::TMO_W-1:0]  req_timeout_ms,
   input  wire logic [sts_pkg::NOW_W-1:0]  req_now_ms,
   output      logic                       rsp_valid,
   output      logic                       rsp_kind,
   output      logic [sts_pkg::ID_W-1:0]   rsp_fired_id,
   output      logic signed [sts_pkg::REM_W-1:0] rsp_remaining_ms,
   output      logic                       rsp_last
);
   import sts_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   assign busy = queue_full;

   // Classify incoming transactions
   sts_front #(
      .TIMERS (TIMERS)
   ) u_front (
      .start          (start),
      .req_action     (req_action),
      .req_timer_id   (req_timer_id),
      .req_timeout_ms (req_timeout_ms),
      .req_now_ms     (req_now_ms),
      .queue_full     (queue_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // Hold commands between front and list engine
   sts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Carry out commands on the sorted list
   sts_back #(
      .TIMERS (TIMERS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_fired_id     (rsp_fired_id),
      .rsp_remaining_ms (rsp_remaining_ms),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
